### rtl/core/ppo_pkg.sv
// Package: payload types, configuration record and mode codes of the pixel point operation.
`timescale 1ns / 1ps

package ppo_pkg;

    localparam logic [1:0] MODE_ADD       = 2'd0;
    localparam logic [1:0] MODE_MUL       = 2'd1;
    localparam logic [1:0] MODE_THRESHOLD = 2'd2;
    localparam logic [1:0] MODE_PASS      = 2'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_GAIN   = 3'd2;
    localparam logic [2:0] REG_LOW    = 3'd3;
    localparam logic [2:0] REG_HIGH   = 3'd4;
    localparam logic [2:0] REG_KEEP   = 3'd5;
    localparam logic [2:0] REG_INVERT = 3'd6;

    localparam int unsigned ADDR_W = 5;

    localparam logic [7:0] BYTE_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       last_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_out;
    } t_pix_out;

    typedef struct packed {
        logic [1:0]         operation_mode;
        logic signed [8:0]  add_offset;
        logic signed [15:0] gain_q8_8;
        logic signed [9:0]  low_level;
        logic signed [9:0]  high_level;
        logic               keep_value;
        logic               invert_output;
    } t_cfg;

endpackage

### rtl/core/ppo_cfg.sv
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module ppo_cfg
    import ppo_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg       r_cfg;
    logic       n_wr;
    logic [2:0] n_idx;

    assign pready = 1'b1;
    assign n_wr   = psel & penable & pwrite;
    assign n_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.operation_mode <= MODE_ADD;
            r_cfg.add_offset     <= 9'sd0;
            r_cfg.gain_q8_8      <= 16'sd256;
            r_cfg.low_level      <= 10'sd0;
            r_cfg.high_level     <= 10'sd255;
            r_cfg.keep_value     <= 1'b0;
            r_cfg.invert_output  <= 1'b0;
        end else if (n_wr) begin
            case (n_idx)
                REG_MODE:   r_cfg.operation_mode <= pwdata[1:0];
                REG_OFFSET: r_cfg.add_offset     <= $signed(pwdata[8:0]);
                REG_GAIN:   r_cfg.gain_q8_8      <= $signed(pwdata[15:0]);
                REG_LOW:    r_cfg.low_level      <= $signed(pwdata[9:0]);
                REG_HIGH:   r_cfg.high_level     <= $signed(pwdata[9:0]);
                REG_KEEP:   r_cfg.keep_value     <= pwdata[0];
                REG_INVERT: r_cfg.invert_output  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (n_idx)
            REG_MODE:   prdata = {30'd0, r_cfg.operation_mode};
            REG_OFFSET: prdata = {23'd0, r_cfg.add_offset};
            REG_GAIN:   prdata = {16'd0, r_cfg.gain_q8_8};
            REG_LOW:    prdata = {22'd0, r_cfg.low_level};
            REG_HIGH:   prdata = {22'd0, r_cfg.high_level};
            REG_KEEP:   prdata = {31'd0, r_cfg.keep_value};
            REG_INVERT: prdata = {31'd0, r_cfg.invert_output};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/ppo_chan.sv
// Three-stage datapath for one 8-bit colour channel.
`timescale 1ns / 1ps

module ppo_chan
    import ppo_pkg::*;
(
    input  logic       i_clk,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_x,
    output logic [7:0] o_y
);

    // stage 1: sum, product and window compares
    logic signed [10:0] r_sum;
    logic signed [24:0] r_prod;
    logic               r_gt_low;
    logic               r_lt_high;
    logic [7:0]         r_x1;

    logic signed [9:0]  n_xs;
    logic signed [10:0] n_sum;
    logic signed [24:0] n_prod;

    assign n_xs   = $signed({2'b00, i_x});
    assign n_sum  = $signed({3'b000, i_x}) + {{2{i_cfg.add_offset[8]}}, i_cfg.add_offset};
    assign n_prod = {{9{i_cfg.gain_q8_8[15]}}, i_cfg.gain_q8_8} * $signed({17'd0, i_x});

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_prod    <= n_prod;
        r_gt_low  <= n_xs > i_cfg.low_level;
        r_lt_high <= n_xs < i_cfg.high_level;
        r_x1      <= i_x;
    end

    // stage 2: clamp and select
    logic [7:0] r_res;
    logic [7:0] n_res;
    logic       n_in;

    always_comb begin
        n_in  = 1'b0;
        n_res = r_x1;
        case (i_cfg.operation_mode)
            MODE_ADD: begin
                if (r_sum[10]) begin
                    n_res = 8'd0;
                end else if (r_sum[9:8] != 2'b00) begin
                    n_res = BYTE_MAX;
                end else begin
                    n_res = r_sum[7:0];
                end
            end
            MODE_MUL: begin
                if (r_prod[24]) begin
                    n_res = 8'd0;
                end else if (r_prod[23:16] != 8'd0) begin
                    n_res = BYTE_MAX;
                end else begin
                    n_res = r_prod[15:8];
                end
            end
            MODE_THRESHOLD: begin
                if (!i_cfg.keep_value && (i_cfg.low_level > i_cfg.high_level)) begin
                    n_in = r_gt_low | r_lt_high;
                end else begin
                    n_in = r_gt_low & r_lt_high;
                end
                if (i_cfg.keep_value) begin
                    n_res = n_in ? r_x1 : 8'd0;
                end else begin
                    n_res = n_in ? BYTE_MAX : 8'd0;
                end
            end
            default: n_res = r_x1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // stage 3: optional invert
    logic [7:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_cfg.invert_output && (i_cfg.operation_mode != MODE_PASS)) begin
            r_y <= BYTE_MAX - r_res;
        end else begin
            r_y <= r_res;
        end
    end

    assign o_y = r_y;

endmodule

### rtl/core/pixel_point_operation_core.sv
// Top level: pixel point operation core with register port and pixel pipeline.
// Usage:
//   Pixel input: drive i_pixel and raise start; a beat is taken at every edge
//   with start high and busy low. busy stays low, so one pixel per clock.
//   Result: o_pixel is shown for one cycle with o_valid high, once the pixel
//   has passed the three register stages of each channel datapath (stage 1
//   sum/product/compare, stage 2 clamp and select, stage 3 invert).
//   Throughput is one pixel per cycle.
//   The receiver cannot stall: it must take every beat as it appears.
//   Registers: APB-style port, register i at byte address 4*i, pready always
//   high, writes land at the access cycle. Write them only with the pipe empty.
//   Reset (i_rst_n low, synchronous): all valid bits clear, registers return
//   to mode add, offset 0, gain 1.0, window 0..255, binary, no invert.
`timescale 1ns / 1ps

module pixel_point_operation_core
    import ppo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_pix_in           i_pixel,
    output logic              o_valid,
    output t_pix_out          o_pixel,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       cfg;
    logic [2:0] r_valid;
    logic [2:0] r_last;
    logic       n_accept;
    logic [7:0] red_y;
    logic [7:0] green_y;
    logic [7:0] blue_y;

    assign busy     = 1'b0;
    assign n_accept = start & ~busy;

    ppo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppo_chan u_red (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .i_x   (i_pixel.red_in),
        .o_y   (red_y)
    );

    ppo_chan u_green (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .i_x   (i_pixel.green_in),
        .o_y   (green_y)
    );

    ppo_chan u_blue (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .i_x   (i_pixel.blue_in),
        .o_y   (blue_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 3'b000;
        end else begin
            r_valid <= {r_valid[1:0], n_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[1:0], i_pixel.last_in};
    end

    assign o_valid = r_valid[2];
    assign o_pixel = {red_y, green_y, blue_y, r_last[2]};

endmodule

### verif/pixel_point_operation_core_test.sv
// Testbench: random and directed pixel beats with register settings, checked against a predictor.
`timescale 1ns / 1ps

class point_op_scoreboard;
    logic [1:0] mode;
    int         offset;
    int         gain;
    int         low_lvl;
    int         high_lvl;
    bit         keep;
    bit         invert;
    ppo_pkg::t_pix_out expected_pixels[$];
    int         mismatches;

    function new();
        mode       = ppo_pkg::MODE_ADD;
        offset     = 0;
        gain       = 256;
        low_lvl    = 0;
        high_lvl   = 255;
        keep       = 1'b0;
        invert     = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            ppo_pkg::REG_MODE:   mode     = value[1:0];
            ppo_pkg::REG_OFFSET: offset   = int'($signed(value[8:0]));
            ppo_pkg::REG_GAIN:   gain     = int'($signed(value[15:0]));
            ppo_pkg::REG_LOW:    low_lvl  = int'($signed(value[9:0]));
            ppo_pkg::REG_HIGH:   high_lvl = int'($signed(value[9:0]));
            ppo_pkg::REG_KEEP:   keep     = value[0];
            ppo_pkg::REG_INVERT: invert   = value[0];
            default: ;
        endcase
    endfunction

    function logic [7:0] shade_channel(input logic [7:0] x);
        int xv;
        int r;
        bit hit;
        xv = int'(x);
        if (mode == ppo_pkg::MODE_PASS)
            return x;
        case (mode)
            ppo_pkg::MODE_ADD: r = xv + offset;
            ppo_pkg::MODE_MUL: r = (gain * xv) / 256;
            default: begin
                if (keep) begin
                    r = (xv > low_lvl && xv < high_lvl) ? xv : 0;
                end else begin
                    if (low_lvl > high_lvl)
                        hit = (xv > low_lvl) || (xv < high_lvl);
                    else
                        hit = (xv > low_lvl) && (xv < high_lvl);
                    r = hit ? 255 : 0;
                end
            end
        endcase
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        if (invert)
            r = 255 - r;
        return r[7:0];
    endfunction

    function void note_pixel_in(input ppo_pkg::t_pix_in p);
        ppo_pkg::t_pix_out e;
        e.red_out   = shade_channel(p.red_in);
        e.green_out = shade_channel(p.green_in);
        e.blue_out  = shade_channel(p.blue_in);
        e.last_out  = p.last_in;
        expected_pixels.push_back(e);
    endfunction

    function void check_pixel_out(input ppo_pkg::t_pix_out got);
        ppo_pkg::t_pix_out want;
        if (expected_pixels.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result beat: r=%0d g=%0d b=%0d last=%0b",
                         got.red_out, got.green_out, got.blue_out, got.last_out);
            mismatches++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
            got.blue_out !== want.blue_out || got.last_out !== want.last_out) begin
            if (mismatches < 10)
                $display("pixel mismatch: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                         want.red_out, want.green_out, want.blue_out, want.last_out,
                         got.red_out, got.green_out, got.blue_out, got.last_out);
            mismatches++;
        end
    endfunction
endclass

module pixel_point_operation_core_test;
    import ppo_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         RANDOM_PHASES = 34;
    localparam int         PHASE_BEATS   = 25;
    localparam logic [2:0] REG_UNUSED    = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_pix_in           i_pixel;
    logic              o_valid;
    t_pix_out          o_pixel;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    point_op_scoreboard board;
    int beats_taken;
    int writes_done;
    int cycle_count;
    bit burst;

    pixel_point_operation_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_pixel_in(i_pixel);
                beats_taken++;
            end
            if (o_valid !== 1'b0)
                board.check_pixel_out(o_pixel);
            if (psel && penable && pwrite && pready) begin
                board.write_reg(paddr[4:2], pwdata);
                writes_done++;
            end
        end
    end

    function automatic t_pix_in px(input int r, input int g, input int b, input bit l);
        t_pix_in p;
        p.red_in   = 8'(r);
        p.green_in = 8'(g);
        p.blue_in  = 8'(b);
        p.last_in  = l;
        return p;
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in p;
        p.red_in   = pick_level();
        p.green_in = pick_level();
        p.blue_in  = pick_level();
        p.last_in  = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    function automatic int draw_gap();
        return burst ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic t_cfg make_settings(input logic [1:0] mode, input int off, input int gain,
                                           input int lo, input int hi, input bit keep,
                                           input bit inv);
        t_cfg c;
        c.operation_mode = mode;
        c.add_offset     = 9'(off);
        c.gain_q8_8      = 16'(gain);
        c.low_level      = 10'(lo);
        c.high_level     = 10'(hi);
        c.keep_value     = keep;
        c.invert_output  = inv;
        return c;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.operation_mode = 2'($urandom_range(0, 3));
        c.add_offset     = 9'($urandom_range(0, 511));
        case ($urandom_range(0, 3))
            0:       c.gain_q8_8 = 16'($urandom);
            1:       c.gain_q8_8 = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: c.gain_q8_8 = 16'($urandom_range(0, 1024) - 256);
        endcase
        if ($urandom_range(0, 4) == 0) begin
            c.low_level  = 10'($urandom);
            c.high_level = 10'($urandom);
        end else begin
            c.low_level  = 10'($urandom_range(0, 257) - 1);
            c.high_level = 10'($urandom_range(0, 257) - 1);
        end
        c.keep_value    = 1'($urandom_range(0, 1));
        c.invert_output = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        int done_mark;
        done_mark = writes_done;
        psel      = 1'b1;
        penable   = 1'b0;
        pwrite    = 1'b1;
        paddr     = {idx, 2'b00};
        pwdata    = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(negedge i_clk); while (writes_done == done_mark);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_settings(input t_cfg c);
        logic [31:0] noise;
        noise = $urandom;
        reg_write(REG_MODE,   {noise[31:2], c.operation_mode});
        reg_write(REG_OFFSET, {noise[31:9], c.add_offset});
        reg_write(REG_GAIN,   {noise[31:16], c.gain_q8_8});
        reg_write(REG_LOW,    {noise[31:10], c.low_level});
        reg_write(REG_HIGH,   {noise[31:10], c.high_level});
        reg_write(REG_KEEP,   {noise[31:1], c.keep_value});
        reg_write(REG_INVERT, {noise[31:1], c.invert_output});
        reg_write(REG_UNUSED, noise);
    endtask

    task automatic send_pixel(input t_pix_in p, input int gap);
        int beat_mark;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) begin
                i_pixel = random_pixel();
                @(negedge i_clk);
            end
        end
        beat_mark = beats_taken;
        start     = 1'b1;
        i_pixel   = p;
        do @(negedge i_clk); while (beats_taken == beat_mark);
    endtask

    // drain the pipe before touching registers
    task automatic settle();
        start = 1'b0;
        while (board.expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic directed_phase(input t_cfg c, input t_pix_in a, input t_pix_in b,
                                  input bit both);
        settle();
        apply_settings(c);
        send_pixel(a, draw_gap());
        if (both)
            send_pixel(b, draw_gap());
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_pix_in p_ext;
        t_pix_in p_mid;
        i_clk       = 1'b0;
        board       = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_pixel     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        beats_taken = 0;
        writes_done = 0;
        burst       = 1'b0;
        p_ext       = px(0, 255, 128, 1'b1);
        p_mid       = px(1, 254, 127, 1'b0);
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_pixel(p_ext, draw_gap());
        send_pixel(p_mid, draw_gap());
        directed_phase(make_settings(MODE_ADD, 255, 256, 0, 255, 1'b0, 1'b0), p_ext, p_mid, 1'b1);
        directed_phase(make_settings(MODE_ADD, -255, 256, 0, 255, 1'b0, 1'b1), p_ext, p_mid, 1'b1);
        directed_phase(make_settings(MODE_MUL, 0, 32767, 0, 255, 1'b0, 1'b0), p_ext, p_mid, 1'b0);
        directed_phase(make_settings(MODE_MUL, 0, -32768, 0, 255, 1'b0, 1'b0), p_ext, p_mid, 1'b0);
        directed_phase(make_settings(MODE_MUL, 0, 384, 0, 255, 1'b0, 1'b0), p_ext, p_mid, 1'b1);
        directed_phase(make_settings(MODE_MUL, 0, 255, 0, 255, 1'b0, 1'b0),
                       px(1, 255, 128, 1'b0), p_mid, 1'b0);
        directed_phase(make_settings(MODE_THRESHOLD, 0, 256, 100, 200, 1'b0, 1'b0),
                       px(100, 101, 199, 1'b1), px(200, 0, 255, 1'b0), 1'b1);
        directed_phase(make_settings(MODE_THRESHOLD, 0, 256, 200, 50, 1'b0, 1'b0),
                       px(201, 200, 49, 1'b0), px(50, 128, 255, 1'b1), 1'b1);
        directed_phase(make_settings(MODE_THRESHOLD, 0, 256, -1, 256, 1'b1, 1'b0),
                       p_ext, p_mid, 1'b0);
        directed_phase(make_settings(MODE_THRESHOLD, 0, 256, 200, 50, 1'b1, 1'b1),
                       px(201, 49, 128, 1'b0), p_mid, 1'b0);
        directed_phase(make_settings(MODE_THRESHOLD, 0, 256, 256, -1, 1'b0, 1'b0),
                       p_ext, p_mid, 1'b0);
        directed_phase(make_settings(MODE_THRESHOLD, 0, 256, 100, 100, 1'b0, 1'b0),
                       px(100, 99, 101, 1'b0), p_mid, 1'b0);
        directed_phase(make_settings(MODE_PASS, 77, 512, 10, 20, 1'b1, 1'b1), p_ext, p_mid, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            apply_settings(random_settings());
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_BEATS; k++)
                send_pixel(random_pixel(), draw_gap());
        end

        settle();
        if (board.mismatches == 0 && board.expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### pixel_point_operation_core.f
rtl/core/ppo_pkg.sv
rtl/core/ppo_cfg.sv
rtl/core/ppo_chan.sv
rtl/core/pixel_point_operation_core.sv
verif/pixel_point_operation_core_test.sv
